/* rtl/msp_pkg.sv */
`timescale 1ns / 1ps

package msp_pkg;

    // Width of the signed product accumulator: three 8-bit gains times a
    // 16-bit signed operand plus a 16-bit duty base needs 26 bits.
    localparam int ACC_W = 28;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_I        = 3'd1,
        CFG_GAIN_D        = 3'd2,
        CFG_PWM_LIMIT     = 3'd3,
        CFG_RPM_NUMERATOR = 3'd4
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_ERR  = 6'b001000,
        ST_MAC  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // Status returned by a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    localparam logic [15:0] SPEED_MAX = 16'hFFFF;
    localparam logic [31:0] RPM_NUM_RESET = 32'd60000000;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* rtl/msp_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module msp_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            num,
    input  logic [31:0]            den,
    output msp_pkg::unit_status_t  status,
    output logic [31:0]            quot
);

    logic [31:0] num_sr_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    assign trial = {rem_reg, num_sr_reg[31]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = !diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_sr_reg <= num;
            den_reg    <= den;
            rem_reg    <= '0;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter below.
            num_sr_reg <= {num_sr_reg[30:0], qbit};
            rem_reg    <= qbit ? diff[31:0] : trial[31:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = num_sr_reg;

endmodule

/* rtl/msp_mac.sv */
`timescale 1ns / 1ps

// Serial multiply-accumulate: base + g0*op0 + g1*op1 + g2*op2, one gain bit
// per cycle.
module msp_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [15:0]                op0,
    input  logic signed [15:0]                op1,
    input  logic signed [15:0]                op2,
    input  logic [7:0]                        g0,
    input  logic [7:0]                        g1,
    input  logic [7:0]                        g2,
    input  logic [15:0]                       base,
    output msp_pkg::unit_status_t             status,
    output logic [msp_pkg::ACC_W-1:0]         acc
);

    localparam int AW = msp_pkg::ACC_W;

    logic [23:0]          gain_sr_reg;
    logic [AW-1:0]        mcand_reg;
    logic [AW-1:0]        acc_reg;
    logic [15:0]          op1_reg;
    logic [15:0]          op2_reg;
    logic [2:0]           bit_reg;
    logic [1:0]           phase_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [15:0]          next_op;

    assign next_op = (phase_reg == 2'd0) ? op1_reg : op2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            bit_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                bit_reg   <= '0;
                phase_reg <= '0;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd2)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            gain_sr_reg <= {g2, g1, g0};
            mcand_reg   <= {{(AW-16){op0[15]}}, op0};
            acc_reg     <= {{(AW-16){1'b0}}, base};
            op1_reg     <= op1;
            op2_reg     <= op2;
        end
        else if (busy_reg)
        begin
            if (gain_sr_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            gain_sr_reg <= {1'b0, gain_sr_reg[23:1]};
            if (bit_reg == 3'd7)
            begin
                mcand_reg <= {{(AW-16){next_op[15]}}, next_op};
            end
            else
            begin
                mcand_reg <= {mcand_reg[AW-2:0], 1'b0};
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign acc         = acc_reg;

endmodule

/* rtl/motor_speed_pid_with_encoder_rpm.sv */
`timescale 1ns / 1ps

// Per-motor speed loop with encoder speed measurement and an incremental PID
// duty update. Each input transfer yields exactly one result transfer. An
// encoder edge item (s_tuser = 0) measures the motor's speed as rpm_numerator
// divided by the microseconds since that motor's previous edge, saturated to
// 65535 (also for a zero period), and records the edge time. A control item
// (s_tuser = 1) forms a saturating 16-bit error, integral and derivative,
// adds gain_p*e + gain_i*sum + gain_d*de to the stored duty, clamps it to
// 0..pwm_limit (0 for a zero target) and latches the direction. The result
// reports the motor's speed, duty and direction after the item. One item is
// in work at a time: an edge item's time is set by the bit-serial divider,
// a control item's by the serial multiply-accumulate that steps through the
// 24 gain bits. A zero-period edge or an item for a motor index at or above
// MOTORS goes from ST_PREP straight to ST_OUT. A new item is taken while the
// previous result still waits in the output register. Configuration writes
// are taken at any time but must only happen while no item is in work.
module motor_speed_pid_with_encoder_rpm #(
    parameter int MOTORS = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: motor_sel[0], stamp_us[32:1], target_rpm[48:33], reverse[49], zero fill.
    input  logic [msp_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: kind[0] (0 encoder edge, 1 control update).
    input  logic                               s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: motor_out[0], speed_rpm[16:1], duty[32:17], dir_out[33], zero fill.
    output logic [msp_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int AW    = msp_pkg::ACC_W;

    // Configuration registers.
    logic [7:0]  gain_p_reg;
    logic [7:0]  gain_i_reg;
    logic [7:0]  gain_d_reg;
    logic [15:0] pwm_limit_reg;
    logic [31:0] rpm_num_reg;

    // Per-motor state.
    logic [31:0]        last_edge_reg [MOTORS];
    logic [15:0]        speed_reg     [MOTORS];
    logic signed [15:0] err_sum_reg   [MOTORS];
    logic signed [15:0] prior_err_reg [MOTORS];
    logic [15:0]        duty_reg      [MOTORS];
    logic               dir_reg       [MOTORS];

    // The item in work.
    logic        kind_reg;
    logic        sel_reg;
    logic [31:0] stamp_reg;
    logic [15:0] target_reg;
    logic        rev_reg;
    logic signed [15:0] err_reg;

    msp_pkg::state_t state_reg;
    msp_pkg::state_t state_next;

    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [msp_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [31:0]      period;
    logic             accept;
    logic             out_load;

    logic signed [17:0] err_wide;
    logic signed [17:0] sum_wide;
    logic signed [17:0] der_wide;
    logic signed [15:0] sum_new;
    logic signed [15:0] der_new;

    msp_pkg::unit_status_t div_status;
    msp_pkg::unit_status_t mac_status;
    logic [31:0]           quot;
    logic [AW-1:0]         acc;
    logic                  div_start;
    logic                  mac_start;
    logic [15:0]           speed_sat;
    logic [15:0]           duty_new;

    assign idx      = IDX_W'(sel_reg);
    assign in_range = 32'(sel_reg) < 32'(MOTORS);
    assign period   = stamp_reg - last_edge_reg[idx];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == msp_pkg::ST_IDLE);
    assign out_load = (state_reg == msp_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    // Error terms, all saturated to the signed 16-bit range.
    assign err_wide = $signed({2'b00, target_reg}) - $signed({2'b00, speed_reg[idx]});
    assign sum_wide = $signed({{2{err_sum_reg[idx][15]}}, err_sum_reg[idx]})
                    + $signed({{2{err_reg[15]}}, err_reg});
    assign der_wide = $signed({{2{err_reg[15]}}, err_reg})
                    - $signed({{2{prior_err_reg[idx][15]}}, prior_err_reg[idx]});
    assign sum_new  = msp_pkg::sat16(sum_wide);
    assign der_new  = msp_pkg::sat16(der_wide);

    assign div_start = (state_reg == msp_pkg::ST_PREP) && !kind_reg && in_range
                     && (period != 32'd0);
    assign mac_start = (state_reg == msp_pkg::ST_ERR);

    msp_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (rpm_num_reg),
        .den    (period),
        .status (div_status),
        .quot   (quot)
    );

    msp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .op0    (err_reg),
        .op1    (sum_new),
        .op2    (der_new),
        .g0     (gain_p_reg),
        .g1     (gain_i_reg),
        .g2     (gain_d_reg),
        .base   (duty_reg[idx]),
        .status (mac_status),
        .acc    (acc)
    );

    assign speed_sat = (quot[31:16] != 16'd0) ? msp_pkg::SPEED_MAX : quot[15:0];

    // Clamp of the new duty: negative or a zero target to zero, above the limit to the limit.
    always_comb
    begin
        if ((target_reg == 16'd0) || acc[AW-1])
        begin
            duty_new = 16'd0;
        end
        else if (acc[AW-2:0] > {{(AW-17){1'b0}}, pwm_limit_reg})
        begin
            duty_new = pwm_limit_reg;
        end
        else
        begin
            duty_new = acc[15:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = msp_pkg::ST_PREP;
                end
            end
            msp_pkg::ST_PREP:
            begin
                if (!in_range)
                begin
                    state_next = msp_pkg::ST_OUT;
                end
                else if (kind_reg)
                begin
                    state_next = msp_pkg::ST_ERR;
                end
                else if (period == 32'd0)
                begin
                    state_next = msp_pkg::ST_OUT;
                end
                else
                begin
                    state_next = msp_pkg::ST_DIV;
                end
            end
            msp_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = msp_pkg::ST_OUT;
                end
            end
            msp_pkg::ST_ERR:
            begin
                state_next = msp_pkg::ST_MAC;
            end
            msp_pkg::ST_MAC:
            begin
                if (mac_status.done)
                begin
                    state_next = msp_pkg::ST_OUT;
                end
            end
            msp_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = msp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= msp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= 8'd1;
            gain_i_reg    <= 8'd1;
            gain_d_reg    <= 8'd1;
            pwm_limit_reg <= 16'hFFFF;
            rpm_num_reg   <= msp_pkg::RPM_NUM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msp_pkg::CFG_GAIN_P:        gain_p_reg    <= cfg_data[7:0];
                msp_pkg::CFG_GAIN_I:        gain_i_reg    <= cfg_data[7:0];
                msp_pkg::CFG_GAIN_D:        gain_d_reg    <= cfg_data[7:0];
                msp_pkg::CFG_PWM_LIMIT:     pwm_limit_reg <= cfg_data[15:0];
                msp_pkg::CFG_RPM_NUMERATOR: rpm_num_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Item capture and the per-item error register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            sel_reg    <= s_tdata[0];
            stamp_reg  <= s_tdata[32:1];
            target_reg <= s_tdata[48:33];
            rev_reg    <= s_tdata[49];
        end
        if (state_reg == msp_pkg::ST_PREP)
        begin
            err_reg <= msp_pkg::sat16(err_wide);
        end
    end

    // Per-motor state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                last_edge_reg[m] <= '0;
                speed_reg[m]     <= '0;
                err_sum_reg[m]   <= '0;
                prior_err_reg[m] <= '0;
                duty_reg[m]      <= '0;
                dir_reg[m]       <= 1'b0;
            end
        end
        else
        begin
            if ((state_reg == msp_pkg::ST_PREP) && in_range && !kind_reg
                && (period == 32'd0))
            begin
                // An edge whose stamp equals the motor's stored edge time reads as the top speed.
                speed_reg[idx]     <= msp_pkg::SPEED_MAX;
                last_edge_reg[idx] <= stamp_reg;
            end
            if ((state_reg == msp_pkg::ST_DIV) && div_status.done)
            begin
                speed_reg[idx]     <= speed_sat;
                last_edge_reg[idx] <= stamp_reg;
            end
            if (state_reg == msp_pkg::ST_ERR)
            begin
                err_sum_reg[idx]   <= sum_new;
                prior_err_reg[idx] <= err_reg;
            end
            if ((state_reg == msp_pkg::ST_MAC) && mac_status.done)
            begin
                duty_reg[idx] <= duty_new;
                dir_reg[idx]  <= rev_reg;
            end
        end
    end

    // Result register; an item for an absent motor reports zeros.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (in_range)
            begin
                m_tdata_reg <= {6'd0, dir_reg[idx], duty_reg[idx], speed_reg[idx], sel_reg};
            end
            else
            begin
                m_tdata_reg <= {6'd0, 1'b0, 16'd0, 16'd0, sel_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
